/* design/rsd_pkg.sv */
// Shared types, codes and defaults for the RRIP set-dueling replacement block.
`timescale 1ns / 1ps
`default_nettype none

package rsd_pkg;

	// Default configuration.
	localparam int DEF_SETS               = 2048;
	localparam int DEF_WAYS               = 16;
	localparam int DEF_SELECTOR_WIDTH     = 10;
	localparam int DEF_LEADERS_PER_POLICY = 32;

	// Fixed field widths of the request and response.
	localparam int IN_SET_W  = 11;
	localparam int IN_WAY_W  = 4;
	localparam int ADDR_W    = 64;
	localparam int MASK_W    = 16;
	localparam int RRV_W     = 2;
	localparam int CONF_W    = 2;

	// Re-reference values.
	localparam logic [RRV_W-1:0] RRV_MAX         = 2'd3;
	localparam logic [RRV_W-1:0] RRV_INSERT_NEAR = 2'd2;
	localparam logic [RRV_W-1:0] RRV_INSERT_FAR  = 2'd3;
	localparam logic [RRV_W-1:0] RRV_HIT         = 2'd0;

	// Stream confidence limits.
	localparam logic [CONF_W-1:0] CONF_MAX    = 2'd3;
	localparam logic [CONF_W-1:0] CONF_STREAM = 2'd2;

	// Request function codes.
	localparam logic FUNC_VICTIM = 1'b0;
	localparam logic FUNC_UPDATE = 1'b1;

	// Per-set stride detector record.
	typedef struct packed {
		logic [ADDR_W-1:0] prior_address;
		logic [ADDR_W-1:0] prior_delta;
		logic [CONF_W-1:0] confidence;
	} stride_rec_t;

	// Control states: clearing the memories after reset, then running.
	typedef enum logic [1:0] {
		ST_CLEAR = 2'b01,
		ST_RUN   = 2'b10
	} ctrl_state_t;

endpackage

`default_nettype wire

/* design/rsd_ram.sv */
// Simple dual-port synchronous RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none

module rsd_ram
	import rsd_pkg::*;
#(
	parameter int DEPTH = DEF_SETS,
	parameter int WIDTH = 2 * DEF_WAYS,
	parameter int AW    = $clog2(DEF_SETS)
) (
	input  wire logic             clk,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Read returns the contents before a same-cycle write.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

/* design/rsd_victim.sv */
// Victim selection and aging over one set's row of re-reference values.
`timescale 1ns / 1ps
`default_nettype none

module rsd_victim
	import rsd_pkg::*;
#(
	parameter int WAYS  = DEF_WAYS,
	parameter int WAY_W = $clog2(DEF_WAYS)
) (
	input  wire logic [RRV_W*WAYS-1:0] row,
	input  wire logic [WAYS-1:0]       valid,
	output logic      [WAY_W-1:0]      victim,
	output logic      [RRV_W*WAYS-1:0] new_row
);

	logic [WAYS-1:0]       is3, is2, is1, aged3;
	logic                  any_invalid;
	logic [WAY_W-1:0]      inv_way, aged_way;
	logic [RRV_W-1:0]      top, step;
	logic [RRV_W*WAYS-1:0] aged_row;
	logic [RRV_W:0]        sum;

	always_comb begin
		for (int w = 0; w < WAYS; w++) begin
			is3[w] = row[RRV_W*w +: RRV_W] == 2'd3;
			is2[w] = row[RRV_W*w +: RRV_W] == 2'd2;
			is1[w] = row[RRV_W*w +: RRV_W] == 2'd1;
		end
		// The largest value in the set decides how far every way ages.
		if (|is3) begin
			top = 2'd3;
		end else if (|is2) begin
			top = 2'd2;
		end else if (|is1) begin
			top = 2'd1;
		end else begin
			top = 2'd0;
		end
		step = RRV_MAX - top;
		aged_row = '0;
		aged3 = '0;
		for (int w = 0; w < WAYS; w++) begin
			sum = {1'b0, row[RRV_W*w +: RRV_W]} + {1'b0, step};
			aged_row[RRV_W*w +: RRV_W] = (sum > {1'b0, RRV_MAX}) ? RRV_MAX : sum[RRV_W-1:0];
			aged3[w] = (sum >= {1'b0, RRV_MAX});
		end
		// Lowest index wins in both searches.
		inv_way = '0;
		aged_way = '0;
		any_invalid = 1'b0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (!valid[w]) begin
				inv_way = WAY_W'(w);
				any_invalid = 1'b1;
			end
			if (aged3[w]) begin
				aged_way = WAY_W'(w);
			end
		end
		victim  = any_invalid ? inv_way : aged_way;
		new_row = any_invalid ? row : aged_row;
	end

endmodule

`default_nettype wire

/* design/rsd_stride.sv */
// Per-set stride detector update: confidence counting and stream flag.
`timescale 1ns / 1ps
`default_nettype none

module rsd_stride
	import rsd_pkg::*;
(
	input  wire stride_rec_t       rec,
	input  wire logic [ADDR_W-1:0] address,
	output stride_rec_t            new_rec,
	output logic                   seen
);

	logic [ADDR_W-1:0] delta;
	logic              has_history;
	logic              match;
	logic [CONF_W-1:0] conf;

	always_comb begin
		delta       = address - rec.prior_address;
		has_history = rec.prior_address != '0;
		match       = (delta == rec.prior_delta) && (delta != '0);
		conf        = rec.confidence;
		if (has_history) begin
			if (match) begin
				if (conf != CONF_MAX) begin
					conf = conf + 2'd1;
				end
			end else if (conf != '0) begin
				conf = conf - 2'd1;
			end
		end
		seen                  = has_history && (conf >= CONF_STREAM);
		new_rec.prior_address = address;
		new_rec.prior_delta   = delta;
		new_rec.confidence    = conf;
	end

endmodule

`default_nettype wire

/* design/rrip_set_dueling_stream_bypass.sv */
// Top level: RRIP replacement with set dueling and stream bypass, memory pipeline.
// Requests pass stage 1, then the output register. Throughput: one transaction per cycle
//   while the output is not stalled, set by the single read-modify-write pass per set over
//   one row of each memory; back-to-back requests to the same set are forwarded.
// Reset: arst_n clears control state, then a clearing pass over SETS rows (2048 by default)
//   zeroes both memories; request transactions are stalled until it finishes.
// The policy selector resets to its midpoint.
`timescale 1ns / 1ps
`default_nettype none

module rrip_set_dueling_stream_bypass
	import rsd_pkg::*;
#(
	parameter int SETS               = DEF_SETS,
	parameter int WAYS               = DEF_WAYS,
	parameter int SELECTOR_WIDTH     = DEF_SELECTOR_WIDTH,
	parameter int LEADERS_PER_POLICY = DEF_LEADERS_PER_POLICY
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                req_valid,
	output logic                     req_stall,
	input  wire logic                func,
	input  wire logic [IN_SET_W-1:0] set_index,
	input  wire logic [IN_WAY_W-1:0] way_index,
	input  wire logic [ADDR_W-1:0]   address,
	input  wire logic                was_hit,
	input  wire logic [MASK_W-1:0]   valid_mask,
	output logic                     rsp_valid,
	input  wire logic                rsp_stall,
	output logic [IN_WAY_W-1:0]      victim_way,
	output logic                     stream_seen,
	output logic                     bypassed
);

	localparam int SET_W   = $clog2(SETS);
	localparam int WAY_W   = $clog2(WAYS);
	localparam int ROW_W   = RRV_W * WAYS;
	localparam int REC_W   = $bits(stride_rec_t);
	localparam int RED_W   = 20;
	localparam int LEAD_W  = 17;
	localparam logic [SET_W-1:0] LAST_SET = SET_W'(SETS - 1);
	localparam logic [SELECTOR_WIDTH-1:0] SEL_MID = SELECTOR_WIDTH'(1 << (SELECTOR_WIDTH - 1));
	localparam logic [SELECTOR_WIDTH-1:0] SEL_TOP = '1;

	// Control and clearing pass.
	ctrl_state_t               state_q;
	logic [SET_W-1:0]          clr_q;
	logic                      clearing;

	// Handshake.
	logic                      req_accept;
	logic                      s1_move;

	// Request set reduced modulo SETS.
	logic [RED_W-1:0]          red;
	logic [SET_W-1:0]          set_idx;
	logic [WAYS-1:0]           mask_ext;

	// Stage 1: request waiting for its memory rows.
	logic                      s1_valid_q;
	logic                      func_s1;
	logic [SET_W-1:0]          set_s1;
	logic [IN_WAY_W-1:0]       way_s1;
	logic [ADDR_W-1:0]         addr_s1;
	logic                      hit_s1;
	logic [WAYS-1:0]           mask_s1;
	logic                      fwd_s1;

	// Memory ports and forwarding copies of the last written rows.
	logic [ROW_W-1:0]          rrv_rdata;
	logic [REC_W-1:0]          rec_rdata;
	logic                      mem_we;
	logic [SET_W-1:0]          mem_waddr;
	logic [ROW_W-1:0]          rrv_wdata;
	stride_rec_t               rec_wdata;
	logic [ROW_W-1:0]          rrv_wb_q;
	stride_rec_t               rec_wb_q;

	// Stage 1 datapath.
	logic [ROW_W-1:0]          row;
	stride_rec_t               rec;
	logic [WAY_W-1:0]          vic_way;
	logic [ROW_W-1:0]          vic_row;
	stride_rec_t               det_rec;
	logic                      det_seen;
	logic                      way_ok;
	logic                      lead_near;
	logic                      lead_far;
	logic                      insert;
	logic [RRV_W-1:0]          ins_val;
	logic [ROW_W-1:0]          new_row;
	stride_rec_t               new_rec;
	logic [5:0]                vic_wide;
	logic [SELECTOR_WIDTH-1:0] psel_q;

	// Output register.
	logic                      rsp_valid_q;
	logic [IN_WAY_W-1:0]       victim_way_q;
	logic                      stream_seen_q;
	logic                      bypassed_q;

	assign clearing = (state_q == ST_CLEAR);

	// Stage 1 advances whenever the output register is empty or being drained.
	assign s1_move    = s1_valid_q && (!rsp_valid_q || !rsp_stall);
	assign req_stall  = clearing || (s1_valid_q && !s1_move);
	assign req_accept = req_valid && !req_stall;

	// The set index is taken modulo SETS with a short restoring-subtract chain; the user must
	// keep SETS at least 128 (not enforced), so the 11-bit index needs at most four steps.
	always_comb begin
		red = RED_W'(set_index);
		for (int k = 3; k >= 0; k--) begin
			if (red >= RED_W'(SETS << k)) begin
				red = red - RED_W'(SETS << k);
			end
		end
		set_idx = SET_W'(red);
	end

	// Mask bits beyond the input field count as invalid ways.
	for (genvar g = 0; g < WAYS; g++) begin : g_mask
		if (g < MASK_W) begin : g_in
			assign mask_ext[g] = valid_mask[g];
		end else begin : g_out
			assign mask_ext[g] = 1'b0;
		end
	end

	// Clearing pass after reset: one row of each memory per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_SET) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					state_q <= ST_RUN;
				end
				default: begin
					state_q <= ST_CLEAR;
					clr_q   <= '0;
				end
			endcase
		end
	end

	// Stage 1 control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (req_accept) begin
			s1_valid_q <= 1'b1;
		end else if (s1_move) begin
			s1_valid_q <= 1'b0;
		end
	end

	// Stage 1 payload. The forward flag marks a request that reads the set being
	// written back in the same cycle: the memory then returns the old row, so the
	// written copy is used instead.
	always_ff @(posedge clk) begin
		if (req_accept) begin
			func_s1 <= func;
			set_s1  <= set_idx;
			way_s1  <= way_index;
			addr_s1 <= address;
			hit_s1  <= was_hit;
			mask_s1 <= mask_ext;
			fwd_s1  <= s1_move && (set_s1 == set_idx);
		end
	end

	// Write-back copies, kept until the next write-back.
	always_ff @(posedge clk) begin
		if (s1_move) begin
			rrv_wb_q <= new_row;
			rec_wb_q <= new_rec;
		end
	end

	assign mem_we    = clearing || s1_move;
	assign mem_waddr = clearing ? clr_q : set_s1;
	assign rrv_wdata = clearing ? '0 : new_row;
	assign rec_wdata = clearing ? '0 : new_rec;

	// One row of re-reference values per set.
	rsd_ram #(
		.DEPTH (SETS),
		.WIDTH (ROW_W),
		.AW    (SET_W)
	) u_rrv_ram (
		.clk     (clk),
		.rd_en   (req_accept),
		.rd_addr (set_idx),
		.rd_data (rrv_rdata),
		.wr_en   (mem_we),
		.wr_addr (mem_waddr),
		.wr_data (rrv_wdata)
	);

	// One stride detector record per set.
	rsd_ram #(
		.DEPTH (SETS),
		.WIDTH (REC_W),
		.AW    (SET_W)
	) u_rec_ram (
		.clk     (clk),
		.rd_en   (req_accept),
		.rd_addr (set_idx),
		.rd_data (rec_rdata),
		.wr_en   (mem_we),
		.wr_addr (mem_waddr),
		.wr_data (rec_wdata)
	);

	assign row = fwd_s1 ? rrv_wb_q : rrv_rdata;
	assign rec = fwd_s1 ? rec_wb_q : stride_rec_t'(rec_rdata);

	rsd_victim #(
		.WAYS  (WAYS),
		.WAY_W (WAY_W)
	) u_victim (
		.row     (row),
		.valid   (mask_s1),
		.victim  (vic_way),
		.new_row (vic_row)
	);

	rsd_stride u_stride (
		.rec     (rec),
		.address (addr_s1),
		.new_rec (det_rec),
		.seen    (det_seen)
	);

	// Insertion policy: the two groups of leader sets fix the insertion value,
	// follower sets take it from the policy selector.
	assign way_ok    = {2'b00, way_s1} < 6'(WAYS);
	assign lead_near = LEAD_W'(set_s1) < LEAD_W'(LEADERS_PER_POLICY);
	assign lead_far  = !lead_near && (LEAD_W'(set_s1) < LEAD_W'(2 * LEADERS_PER_POLICY));
	assign insert    = (func_s1 == FUNC_UPDATE) && !hit_s1 && !det_seen;

	always_comb begin
		if (lead_near) begin
			ins_val = RRV_INSERT_NEAR;
		end else if (lead_far) begin
			ins_val = RRV_INSERT_FAR;
		end else if (psel_q >= SEL_MID) begin
			ins_val = RRV_INSERT_NEAR;
		end else begin
			ins_val = RRV_INSERT_FAR;
		end
	end

	// New contents of the set's rows.
	always_comb begin
		if (func_s1 == FUNC_VICTIM) begin
			new_row = vic_row;
			new_rec = rec;
		end else begin
			new_row = row;
			new_rec = det_rec;
			for (int w = 0; w < WAYS; w++) begin
				if (way_ok && (WAY_W'(way_s1) == WAY_W'(w))) begin
					if (hit_s1) begin
						new_row[RRV_W*w +: RRV_W] = RRV_HIT;
					end else if (insert) begin
						new_row[RRV_W*w +: RRV_W] = ins_val;
					end
				end
			end
		end
	end

	// Policy selector: moves on inserted misses in leader sets, saturating.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			psel_q <= SEL_MID;
		end else if (s1_move && insert) begin
			if (lead_near && (psel_q != SEL_TOP)) begin
				psel_q <= psel_q + 1'b1;
			end else if (lead_far && (psel_q != '0)) begin
				psel_q <= psel_q - 1'b1;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (s1_move) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign vic_wide = 6'(vic_way);

	always_ff @(posedge clk) begin
		if (s1_move) begin
			victim_way_q  <= (func_s1 == FUNC_VICTIM) ? vic_wide[IN_WAY_W-1:0] : '0;
			stream_seen_q <= (func_s1 == FUNC_UPDATE) && det_seen;
			bypassed_q    <= (func_s1 == FUNC_UPDATE) && !hit_s1 && det_seen;
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign victim_way  = victim_way_q;
	assign stream_seen = stream_seen_q;
	assign bypassed    = bypassed_q;

	// A victim request never moves the policy selector.
	a_psel_victim: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_move && (func_s1 == FUNC_VICTIM)) |=> (psel_q == $past(psel_q)))
		else $error("policy selector moved on a victim request");

	// A request held in stage 1 is not dropped while the output is stalled.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !s1_move) |=> s1_valid_q)
		else $error("stage 1 transaction lost while stalled");

	// A bypassed miss always comes with a detected stream.
	a_bypass_stream: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (!bypassed || stream_seen))
		else $error("bypass without a detected stream");

	// No request is in flight while the memories are being cleared.
	a_clear_idle: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> (!s1_valid_q && !rsp_valid_q))
		else $error("transaction in flight during clearing pass");

endmodule

`default_nettype wire
